// ===== hw/rtl/mied_pkg.sv =====
package mied_pkg;

    localparam int NUM_AXES  = 3;
    localparam int BOX_W     = 15;
    localparam int OUT_W     = 17;
    localparam int MAG_W     = 17;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam logic [REG_IDX_W-1:0] REG_BOX_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BOX_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOX_Z = 2'd2;

    localparam logic [BOX_W-1:0] BOX_X_RST = 15'd1792;
    localparam logic [BOX_W-1:0] BOX_Y_RST = 15'd1792;
    localparam logic [BOX_W-1:0] BOX_Z_RST = 15'd5120;

    typedef logic [BOX_W-1:0] t_box_len;

endpackage

// ===== hw/rtl/mied_if.sv =====
interface mied_in_if #(
    parameter int COORD_WIDTH = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] start_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;

    modport source (
        output valid, start_x, start_y, start_z, end_x, end_y, end_z,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
        output ready
    );
endinterface

interface mied_out_if import mied_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] distance;

    modport source (
        output valid, distance,
        input  ready
    );
    modport sink (
        input  valid, distance,
        output ready
    );
endinterface

// ===== hw/rtl/min_image_end_to_end_distance.sv =====
// Channel   Direction  Handshake        Word
// i_chain   in         valid / ready    start_x..z, end_x..z (signed)
// o_dist    out        valid / ready    distance (unsigned, 17 bits)
// APB       in         psel & penable   box_len_x/y/z at 0x0, 0x4, 0x8
//
// One word is accepted per cycle while i_chain.ready is high; each word passes
// through five arithmetic stages, an 18-stage square root and an output stage.
// Reset is synchronous and clears all valid bits; box lengths return to defaults.
// A skid register behind the output stage holds one word while o_dist stalls,
// and i_chain.ready drops only while that register is full.
module min_image_end_to_end_distance import mied_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mied_in_if.sink            i_chain,
    mied_out_if.source         o_dist,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CMP_W = (COORD_WIDTH + 2 > BOX_W + 2) ? COORD_WIDTH + 2 : BOX_W + 2;

    t_box_len                r_box [NUM_AXES];
    logic [REG_IDX_W-1:0]    w_reg_idx;
    logic                    w_cfg_wr;

    logic                    w_en;
    logic signed [COORD_WIDTH-1:0] w_start [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_end   [NUM_AXES];

    logic signed [COORD_WIDTH:0]   n_s1_d  [NUM_AXES];
    logic signed [CMP_W-1:0]       n_d_ext [NUM_AXES];
    logic signed [CMP_W-1:0]       n_len   [NUM_AXES];
    logic signed [CMP_W-1:0]       n_d2    [NUM_AXES];
    logic signed [CMP_W-1:0]       n_s2_d  [NUM_AXES];
    logic [CMP_W-1:0]              n_mag   [NUM_AXES];
    logic [NUM_AXES-1:0]           n_s3_sat;

    logic                          r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;
    logic signed [COORD_WIDTH:0]   r_s1_d   [NUM_AXES];
    logic signed [CMP_W-1:0]       r_s2_d   [NUM_AXES];
    logic [MAG_W-1:0]              r_s3_mag [NUM_AXES];
    logic                          r_s3_sat;
    logic [SQ_W-1:0]               r_s4_sq  [NUM_AXES];
    logic                          r_s4_sat;
    logic [SUM_W-1:0]              r_s5_sum;
    logic                          r_s5_sat;

    logic [REM_W-1:0]              r_rt_rem  [ROOT_W];
    logic [ROOT_W-1:0]             r_rt_root [ROOT_W];
    logic [SUM_W-1:0]              r_rt_num  [ROOT_W];
    logic [ROOT_W-1:0]             r_rt_v;
    logic [ROOT_W-1:0]             r_rt_sat;

    logic [OUT_W-1:0]              n_out_d;
    logic                          r_out_v;
    logic [OUT_W-1:0]              r_out_d;
    logic                          r_skid_v;
    logic [OUT_W-1:0]              r_skid_d;

    assign w_reg_idx = paddr[PADDR_W-1:2];
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box[0] <= BOX_X_RST;
            r_box[1] <= BOX_Y_RST;
            r_box[2] <= BOX_Z_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_BOX_X: r_box[0] <= pwdata[BOX_W-1:0];
                REG_BOX_Y: r_box[1] <= pwdata[BOX_W-1:0];
                REG_BOX_Z: r_box[2] <= pwdata[BOX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_BOX_X: prdata = PDATA_W'(r_box[0]);
            REG_BOX_Y: prdata = PDATA_W'(r_box[1]);
            REG_BOX_Z: prdata = PDATA_W'(r_box[2]);
            default:   prdata = '0;
        endcase
    end

    assign w_en          = !r_skid_v;
    assign i_chain.ready = w_en;

    assign w_start[0] = i_chain.start_x;
    assign w_start[1] = i_chain.start_y;
    assign w_start[2] = i_chain.start_z;
    assign w_end[0]   = i_chain.end_x;
    assign w_end[1]   = i_chain.end_y;
    assign w_end[2]   = i_chain.end_z;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_s1_d[a]  = (COORD_WIDTH + 1)'(w_end[a]) - (COORD_WIDTH + 1)'(w_start[a]);
            n_d_ext[a] = CMP_W'(r_s1_d[a]);
            n_len[a]   = signed'(CMP_W'(r_box[a]));
            n_d2[a]    = n_d_ext[a] <<< 1;
            if (n_d2[a] > n_len[a]) begin
                n_s2_d[a] = n_d_ext[a] - n_len[a];
            end else if (n_d2[a] <= -n_len[a]) begin
                n_s2_d[a] = n_d_ext[a] + n_len[a];
            end else begin
                n_s2_d[a] = n_d_ext[a];
            end
            n_mag[a]    = r_s2_d[a][CMP_W-1] ? CMP_W'(-r_s2_d[a]) : CMP_W'(r_s2_d[a]);
            n_s3_sat[a] = n_mag[a] > CMP_W'(OUT_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_s1_d[a]   <= n_s1_d[a];
                r_s2_d[a]   <= n_s2_d[a];
                r_s3_mag[a] <= n_mag[a][MAG_W-1:0];
                r_s4_sq[a]  <= SQ_W'(r_s3_mag[a]) * SQ_W'(r_s3_mag[a]);
            end
            r_s3_sat <= |n_s3_sat;
            r_s4_sat <= r_s3_sat;
            r_s5_sum <= SUM_W'(r_s4_sq[0]) + SUM_W'(r_s4_sq[1]) + SUM_W'(r_s4_sq[2]);
            r_s5_sat <= r_s4_sat;
        end
    end

    // Restoring square root, one result bit per stage, most significant first.
    for (genvar k = 0; k < ROOT_W; k++) begin : g_rt
        logic [REM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [SUM_W-1:0]  w_num_in;
        logic              w_v_in;
        logic              w_sat_in;
        logic [REM_W-1:0]  n_rem_sh;
        logic [REM_W-1:0]  n_trial;
        logic [REM_W-1:0]  n_rem;
        logic              n_ge;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_num_in  = r_s5_sum;
            assign w_v_in    = r_s5_v;
            assign w_sat_in  = r_s5_sat;
        end else begin : g_next
            assign w_rem_in  = r_rt_rem[k-1];
            assign w_root_in = r_rt_root[k-1];
            assign w_num_in  = r_rt_num[k-1];
            assign w_v_in    = r_rt_v[k-1];
            assign w_sat_in  = r_rt_sat[k-1];
        end

        assign n_rem_sh = {w_rem_in[REM_W-3:0], w_num_in[SUM_W-1 -: 2]};
        assign n_trial  = {w_root_in, 2'b01};
        assign n_ge     = n_rem_sh >= n_trial;
        assign n_rem    = n_ge ? n_rem_sh - n_trial : n_rem_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_v[k] <= 1'b0;
            end else if (w_en) begin
                r_rt_v[k] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rt_rem[k]  <= n_rem;
                r_rt_root[k] <= {w_root_in[ROOT_W-2:0], n_ge};
                r_rt_num[k]  <= w_num_in << 2;
                r_rt_sat[k]  <= w_sat_in;
            end
        end
    end

    assign n_out_d = (r_rt_sat[ROOT_W-1] || (r_rt_root[ROOT_W-1] > ROOT_W'(OUT_MAX)))
                   ? OUT_MAX : r_rt_root[ROOT_W-1][OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
            r_s4_v   <= 1'b0;
            r_s5_v   <= 1'b0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_en) begin
                r_s1_v  <= i_chain.valid;
                r_s2_v  <= r_s1_v;
                r_s3_v  <= r_s2_v;
                r_s4_v  <= r_s3_v;
                r_s5_v  <= r_s4_v;
                r_out_v <= r_rt_v[ROOT_W-1];
            end
            if (r_skid_v) begin
                if (o_dist.ready) begin
                    r_skid_v <= 1'b0;
                end
            end else if (r_out_v && !o_dist.ready) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_d <= n_out_d;
        end
        if (!r_skid_v) begin
            r_skid_d <= r_out_d;
        end
    end

    assign o_dist.valid    = r_skid_v | r_out_v;
    assign o_dist.distance = r_skid_v ? r_skid_d : r_out_d;

endmodule

// ===== hw/rtl/mied_checker.sv =====
module mied_checker import mied_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [OUT_W-1:0] i_distance
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_distance))
        else $error("stalled output word changed or vanished");

    a_busy_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input held off with no output word pending");

    a_busy_after_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_out_valid && !i_out_ready))
        else $error("input ready dropped without an output stall");

endmodule

bind min_image_end_to_end_distance mied_checker u_mied_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_chain.valid),
    .i_in_ready  (i_chain.ready),
    .i_out_valid (o_dist.valid),
    .i_out_ready (o_dist.ready),
    .i_distance  (o_dist.distance)
);

// ===== tb/tb_min_image_end_to_end_distance.sv =====
module tb_min_image_end_to_end_distance;
    import mied_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef struct {
        t_coord p0[3];
        t_coord p1[3];
    } t_chain;

    class t_dist_scoreboard;
        t_box_len box[3];
        logic [OUT_W-1:0] pending_distances[$];
        int n_chains;
        int n_checked;
        int n_bad;

        function new();
            box[0] = BOX_X_RST;
            box[1] = BOX_Y_RST;
            box[2] = BOX_Z_RST;
            n_chains = 0;
            n_checked = 0;
            n_bad = 0;
        endfunction

        function void flag(string what, longint unsigned exp_v, longint unsigned got_v);
            n_bad++;
            if (n_bad <= MAX_REPORTS) begin
                $display("[%0t] mismatch on %s: expected %0d, got %0d",
                         $realtime, what, exp_v, got_v);
            end
        endfunction

        function void set_box(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_BOX_X: box[0] = value[BOX_W-1:0];
                REG_BOX_Y: box[1] = value[BOX_W-1:0];
                REG_BOX_Z: box[2] = value[BOX_W-1:0];
                default: ;
            endcase
        endfunction

        function void check_box(int axis, logic [PDATA_W-1:0] got);
            logic [PDATA_W-1:0] want;
            want = PDATA_W'(box[axis]);
            if (got !== want) begin
                flag($sformatf("box length readback, axis %0d", axis), want, got);
            end
        endfunction

        // Wrap each axis once into the box, then take the floor square root of
        // the summed squares, bit by bit from the top, saturating at OUT_MAX.
        function logic [OUT_W-1:0] wrapped_distance(t_chain c);
            longint d;
            longint len;
            longint unsigned mag;
            longint unsigned sq_sum;
            longint unsigned root;
            longint unsigned trial;
            bit clipped;
            int a;
            int b;
            sq_sum = 0;
            clipped = 1'b0;
            for (a = 0; a < 3; a++) begin
                d = longint'(c.p1[a]) - longint'(c.p0[a]);
                len = longint'(box[a]);
                if (2 * d > len) begin
                    d = d - len;
                end else if (2 * d <= -len) begin
                    d = d + len;
                end
                mag = (d < 0) ? longint'(-d) : longint'(d);
                if (mag > longint'(OUT_MAX)) begin
                    clipped = 1'b1;
                end else begin
                    sq_sum += mag * mag;
                end
            end
            if (clipped) begin
                return OUT_MAX;
            end
            root = 0;
            for (b = 24; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= sq_sum) begin
                    root = trial;
                end
            end
            return (root > longint'(OUT_MAX)) ? OUT_MAX : root[OUT_W-1:0];
        endfunction

        function void note_chain(t_chain c);
            pending_distances.push_back(wrapped_distance(c));
            n_chains++;
        endfunction

        function void check_distance(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (pending_distances.size() == 0) begin
                flag("distance with nothing outstanding", 0, got);
                return;
            end
            want = pending_distances.pop_front();
            n_checked++;
            if (got !== want) begin
                flag("distance", want, got);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    mied_in_if #(.COORD_WIDTH(COORD_W)) chain_if ();
    mied_out_if dist_if ();

    min_image_end_to_end_distance #(
        .COORD_WIDTH(COORD_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chain (chain_if),
        .o_dist  (dist_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_dist_scoreboard sb;
    int src_idle_pct;
    int rx_idle_pct;
    logic rx_hold;
    int cycles;
    int n_settings;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The receiver stalls at random unless a long hold-off is in progress.
    initial begin
        dist_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                dist_if.ready <= 1'b0;
            end else begin
                dist_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (chain_if.valid && chain_if.ready) begin
                sb.note_chain('{p0: '{chain_if.start_x, chain_if.start_y, chain_if.start_z},
                                p1: '{chain_if.end_x, chain_if.end_y, chain_if.end_z}});
            end
            if (dist_if.valid && dist_if.ready) begin
                sb.check_distance(dist_if.distance);
            end
        end
    end

    function automatic t_chain make_chain(t_coord sx, t_coord sy, t_coord sz,
                                          t_coord ex, t_coord ey, t_coord ez);
        t_chain c;
        c.p0 = '{sx, sy, sz};
        c.p1 = '{ex, ey, ez};
        return c;
    endfunction

    function automatic t_coord corner_coord();
        case ($urandom_range(0, 4))
            0: return t_coord'(16'h8000);
            1: return t_coord'(16'h7fff);
            2: return t_coord'(0);
            3: return t_coord'(-1);
            default: return t_coord'($urandom);
        endcase
    endfunction

    // Some words sit near the wrap thresholds of the current box, as many are
    // fully random, and the rest are built from corner values.
    function automatic t_chain random_chain();
        t_chain c;
        int kind;
        int a;
        int half;
        int span;
        kind = $urandom_range(0, 9);
        for (a = 0; a < 3; a++) begin
            if (kind < 4) begin
                c.p0[a] = t_coord'($urandom);
                c.p1[a] = t_coord'($urandom);
            end else if (kind < 8) begin
                half = int'(sb.box[a]) / 2;
                c.p0[a] = t_coord'(int'($urandom_range(0, 4000)) - 2000);
                span = half + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 1) == 1) begin
                    span = -span;
                end
                c.p1[a] = t_coord'(int'(c.p0[a]) + span);
            end else begin
                c.p0[a] = corner_coord();
                c.p1[a] = corner_coord();
            end
        end
        return c;
    endfunction

    task automatic push_chain(t_chain c);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            chain_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        chain_if.valid <= 1'b1;
        chain_if.start_x <= c.p0[0];
        chain_if.start_y <= c.p0[1];
        chain_if.start_z <= c.p0[2];
        chain_if.end_x <= c.p1[0];
        chain_if.end_y <= c.p1[1];
        chain_if.end_z <= c.p1[2];
        @(posedge i_clk);
        while (!chain_if.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        chain_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_distances.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_box(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        sb.set_box(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic verify_box(logic [REG_IDX_W-1:0] idx, int axis);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= PADDR_W'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        sb.check_box(axis, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_boxes(logic [PDATA_W-1:0] bx, logic [PDATA_W-1:0] by,
                             logic [PDATA_W-1:0] bz);
        write_box(REG_BOX_X, bx);
        write_box(REG_BOX_Y, by);
        write_box(REG_BOX_Z, bz);
        verify_box(REG_BOX_X, 0);
        verify_box(REG_BOX_Y, 1);
        verify_box(REG_BOX_Z, 2);
        n_settings++;
    endtask

    task automatic stall_receiver(int n);
        rx_hold <= 1'b1;
        repeat (n) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    task automatic run_phase(int src_pct, int rx_pct, int n, bit with_hold);
        int k;
        src_idle_pct = src_pct;
        rx_idle_pct <= rx_pct;
        if (with_hold) begin
            fork
                stall_receiver(HOLD_CYCLES);
            join_none
        end
        for (k = 0; k < n; k++) begin
            push_chain(random_chain());
        end
        wait_drained();
    endtask

    initial begin
        sb = new();
        n_settings = 1;
        src_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold = 1'b0;
        i_rst_n <= 1'b0;
        chain_if.valid <= 1'b0;
        chain_if.start_x <= '0;
        chain_if.start_y <= '0;
        chain_if.start_z <= '0;
        chain_if.end_x <= '0;
        chain_if.end_y <= '0;
        chain_if.end_z <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        verify_box(REG_BOX_X, 0);
        verify_box(REG_BOX_Y, 1);
        verify_box(REG_BOX_Z, 2);

        // Default boxes: exact thresholds on each side and full-scale spans.
        push_chain(make_chain(0, 0, 0, 0, 0, 0));
        push_chain(make_chain(0, 0, 0, 896, 0, 0));
        push_chain(make_chain(0, 0, 0, 897, 0, 0));
        push_chain(make_chain(0, 0, 0, -896, 0, 0));
        push_chain(make_chain(0, 0, 0, -895, 0, 0));
        push_chain(make_chain(100, -100, 0, 100, 796, 2560));
        push_chain(make_chain(100, -100, 0, 100, 797, 2561));
        push_chain(make_chain(-32768, -32768, -32768, 32767, 32767, 32767));
        push_chain(make_chain(32767, 32767, 32767, -32768, -32768, -32768));
        push_chain(make_chain(-32768, -32768, -32768, -32768, -32768, -32768));
        push_chain(make_chain(16'sh5555, 16'sh5555, 16'sh5555,
                              16'shaaaa, 16'shaaaa, 16'shaaaa));
        push_chain(make_chain(16'shaaaa, 16'sh5555, 16'shaaaa,
                              16'sh5555, 16'shaaaa, 16'sh5555));
        wait_drained();

        // Smallest and largest boxes, and a zero box reached through the
        // ignored upper bits; a write past the last register must be ignored.
        set_boxes(32'd1, 32'd32767, 32'h0000_8000);
        write_box(REG_UNUSED, 32'h0000_1234);
        verify_box(REG_BOX_X, 0);
        verify_box(REG_BOX_Y, 1);
        verify_box(REG_BOX_Z, 2);
        push_chain(make_chain(0, 0, 0, 1, 16383, 0));
        push_chain(make_chain(0, 0, 0, -1, 16384, 0));
        push_chain(make_chain(5, 0, 0, 5, -16383, 0));
        push_chain(make_chain(0, 0, 0, 0, -16384, 0));
        push_chain(make_chain(-32768, -32768, -32768, 32767, 32767, 32767));
        push_chain(make_chain(32767, 32767, 32767, -32768, -32768, -32768));
        push_chain(make_chain(0, 0, 0, 0, 0, 32767));
        wait_drained();

        set_boxes($urandom_range(1, 32767), $urandom_range(1, 32767),
                  $urandom_range(1, 32767));
        run_phase(34, 75, 380, 1'b0);

        set_boxes(32'hffff_ffff, 32'd1, 32'd32767);
        run_phase(75, 34, 380, 1'b0);

        set_boxes($urandom_range(1, 4000), $urandom_range(1, 4000),
                  {17'h1abcd, 15'($urandom_range(1, 4000))});
        run_phase(0, 0, 380, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.pending_distances.size() != 0) begin
            sb.flag("distances still outstanding", 0, sb.pending_distances.size());
        end
        $display("Sent %0d chain words and checked %0d distances over %0d box settings,",
                 sb.n_chains, sb.n_checked, n_settings);
        $display("with random gaps on both sides, a long output hold-off and full rate.");
        if (sb.n_bad == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches in total.", sb.n_bad);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
